// ===== hw/rtl/v3a_pkg.sv =====
// shared types and constants for the three-component vector alu
package v3a_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int LANES = 3;

  typedef enum logic [2:0] {
    OP_DOT = 3'd0,
    OP_CROSS = 3'd1,
    OP_NORM = 3'd2,
    OP_LEN = 3'd3,
    OP_ADD = 3'd4,
    OP_SUB = 3'd5,
    OP_SCALE = 3'd6,
    OP_DIV = 3'd7
  } op_t;
endpackage

// ===== hw/rtl/v3a_isqrt.sv =====
// pipelined floor square root, one result bit per stage
module v3a_isqrt #(
  parameter int IN_W = 66,
  parameter int OUT_W = 33,
  parameter int TAG_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [OUT_W-1:0]    root,
  output logic [TAG_W-1:0]    out_tag
);
  localparam int RW = 2 * OUT_W + 2;

  wire [OUT_W:0][RW-1:0]      rem;
  wire [OUT_W:0][OUT_W-1:0]   q;
  wire [OUT_W:0][TAG_W-1:0]   tg;
  wire [OUT_W:0][IN_W-1:0]    src;
  wire [OUT_W:0]              vld;

  assign rem[0] = '0;
  assign q[0] = '0;
  assign tg[0] = in_tag;
  assign src[0] = radicand;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    localparam int B = OUT_W - 1 - s;
    logic [RW-1:0] r_shift;
    logic [RW-1:0] trial;
    logic [1:0] pair;
    logic v_r;
    logic [RW-1:0] rem_r;
    logic [OUT_W-1:0] q_r;
    logic [TAG_W-1:0] tg_r;
    logic [IN_W-1:0] src_r;
    always_comb begin
      pair[1] = (2 * B + 1 < IN_W) ? src[s][(2*B+1 < IN_W) ? 2*B+1 : 0] : 1'b0;
      pair[0] = (2 * B < IN_W) ? src[s][(2*B < IN_W) ? 2*B : 0] : 1'b0;
      r_shift = {rem[s][RW-3:0], pair};
      trial = RW'({q[s], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vld[s];
      end
      if (en) begin
        tg_r <= tg[s];
        src_r <= src[s];
        if (r_shift >= trial) begin
          rem_r <= r_shift - trial;
          q_r <= {q[s][OUT_W-2:0], 1'b1};
        end else begin
          rem_r <= r_shift;
          q_r <= {q[s][OUT_W-2:0], 1'b0};
        end
      end
    end
    assign vld[s+1] = v_r;
    assign rem[s+1] = rem_r;
    assign q[s+1] = q_r;
    assign tg[s+1] = tg_r;
    assign src[s+1] = src_r;
  end

  assign out_valid = vld[OUT_W];
  assign root = q[OUT_W];
  assign out_tag = tg[OUT_W];
endmodule

// ===== hw/rtl/v3a_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
module v3a_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33,
  parameter int TAG_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [NUM_W-1:0]    quo,
  output logic [TAG_W-1:0]    out_tag
);
  wire [NUM_W:0][DEN_W:0]     rem;
  wire [NUM_W:0][NUM_W-1:0]   nq;
  wire [NUM_W:0][DEN_W-1:0]   dd;
  wire [NUM_W:0][TAG_W-1:0]   tg;
  wire [NUM_W:0]              vld;

  assign rem[0] = '0;
  assign nq[0] = num;
  assign dd[0] = den;
  assign tg[0] = in_tag;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] r_shift;
    logic v_r;
    logic [DEN_W:0] rem_r;
    logic [NUM_W-1:0] nq_r;
    logic [DEN_W-1:0] dd_r;
    logic [TAG_W-1:0] tg_r;
    assign r_shift = {rem[s][DEN_W-1:0], nq[s][NUM_W-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vld[s];
      end
      if (en) begin
        tg_r <= tg[s];
        dd_r <= dd[s];
        if (r_shift >= {1'b0, dd[s]}) begin
          rem_r <= r_shift - {1'b0, dd[s]};
          nq_r <= {nq[s][NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= r_shift;
          nq_r <= {nq[s][NUM_W-2:0], 1'b0};
        end
      end
    end
    assign vld[s+1] = v_r;
    assign rem[s+1] = rem_r;
    assign nq[s+1] = nq_r;
    assign dd[s+1] = dd_r;
    assign tg[s+1] = tg_r;
  end

  assign out_valid = vld[NUM_W];
  assign quo = nq[NUM_W];
  assign out_tag = tg[NUM_W];
endmodule

// ===== hw/rtl/v3a_lane.sv =====
// one component lane: multiply and add or subtract, and a pipelined fixed point divide
module v3a_lane #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = v3a_pkg::WORD_WIDTH_DEF,
  parameter int TAG_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [WORD_WIDTH-1:0]  p0,
  input  logic [WORD_WIDTH-1:0]  q0,
  input  logic [WORD_WIDTH-1:0]  p1,
  input  logic [WORD_WIDTH-1:0]  q1,
  input  logic                   sub1,
  input  logic                   div_valid,
  input  logic [WORD_WIDTH-1:0]  div_num,
  input  logic [WORD_WIDTH:0]    div_den,
  input  logic                   div_neg,
  input  logic [TAG_W-1:0]       div_tag_in,
  output logic [2*WORD_WIDTH+1:0] mul_sum,
  output logic                   div_out_valid,
  output logic [WORD_WIDTH+FRAC_BITS+1:0] div_q,
  output logic [TAG_W-1:0]       div_tag_out
);
  localparam int PW = 2 * WORD_WIDTH;
  localparam int SW = PW + 2;
  localparam int NW = WORD_WIDTH + FRAC_BITS;

  logic signed [PW-1:0] prod0, prod1;
  logic sub1_r;
  logic signed [SW-1:0] sum;
  logic [NW-1:0] q_mag;
  logic [TAG_W:0] t_in, t_out;
  logic dv;

  always_ff @(posedge clk) begin
    if (en) begin
      prod0 <= $signed(p0) * $signed(q0);
      prod1 <= $signed(p1) * $signed(q1);
      sub1_r <= sub1;
      sum <= sub1_r ? (SW'(prod0) - SW'(prod1)) : (SW'(prod0) + SW'(prod1));
    end
  end
  assign mul_sum = sum;

  logic [WORD_WIDTH-1:0] nmag;
  assign nmag = div_num[WORD_WIDTH-1] ? WORD_WIDTH'(-div_num) : div_num;
  assign t_in = {div_neg, div_tag_in};

  v3a_div #(.NUM_W(NW), .DEN_W(WORD_WIDTH + 1), .TAG_W(TAG_W + 1)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(div_valid),
    .num({nmag, {FRAC_BITS{1'b0}}}) , .den(div_den), .in_tag(t_in),
    .out_valid(dv), .quo(q_mag), .out_tag(t_out)
  );

  assign div_out_valid = dv;
  assign div_tag_out = t_out[TAG_W-1:0];
  assign div_q = t_out[TAG_W] ? -{2'b00, q_mag} : {2'b00, q_mag};
endmodule

// ===== hw/rtl/vec3_alu.sv =====
// top level of the three-component vector alu
//
//  port group   dir  handshake          payload
//  input word   in   in_valid/in_ready  operation, a_*, b_*, scalar_in
//  result word  out  out_valid/out_ready r_*, scalar_out, div_zero, saturated
//
// one word per cycle while the pipeline is not stalled; every operation takes the same
// path: input register, multiply stages, stage 3 register, the square root stages,
// the divider stages and the output register.
// the whole pipeline advances when the output register is empty or taken;
// in_ready follows that same enable. rst clears all valid bits.
module vec3_alu #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = v3a_pkg::WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             operation,
  input  logic [WORD_WIDTH-1:0]  a_x,
  input  logic [WORD_WIDTH-1:0]  a_y,
  input  logic [WORD_WIDTH-1:0]  a_z,
  input  logic [WORD_WIDTH-1:0]  b_x,
  input  logic [WORD_WIDTH-1:0]  b_y,
  input  logic [WORD_WIDTH-1:0]  b_z,
  input  logic [WORD_WIDTH-1:0]  scalar_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WORD_WIDTH-1:0]  r_x,
  output logic [WORD_WIDTH-1:0]  r_y,
  output logic [WORD_WIDTH-1:0]  r_z,
  output logic [WORD_WIDTH-1:0]  scalar_out,
  output logic                   div_zero,
  output logic                   saturated
);
  localparam int W = WORD_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 2;
  localparam int NW = W + FRAC_BITS;
  localparam int QW = NW + 2;
  localparam int L = v3a_pkg::LANES;
  localparam int RAD_W = PW + 2;
  localparam int RT_W = W + 1;
  localparam int SQ_LAT = RT_W;
  localparam int TAG_W = 3;

  logic en;
  logic [SW-1:0] sum_l [L];
  logic [QW-1:0] q_l [L];
  logic [TAG_W-1:0] dtag [L];
  logic dval [L];

  // stage 0: input register
  logic v0;
  v3a_pkg::op_t op0;
  logic [W-1:0] a0 [L];
  logic [W-1:0] b0 [L];
  logic [W-1:0] s0;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      op0 <= v3a_pkg::op_t'(operation);
      a0[0] <= a_x; a0[1] <= a_y; a0[2] <= a_z;
      b0[0] <= b_x; b0[1] <= b_y; b0[2] <= b_z;
      s0 <= scalar_in;
    end
  end

  // lane operand selection
  logic [W-1:0] p0 [L];
  logic [W-1:0] q0 [L];
  logic [W-1:0] p1 [L];
  logic [W-1:0] q1 [L];
  logic sub1 [L];
  logic [W-1:0] one_fx;
  assign one_fx = W'(1);

  always_comb begin
    for (int i = 0; i < L; i++) begin
      p0[i] = a0[i]; q0[i] = b0[i]; p1[i] = '0; q1[i] = '0; sub1[i] = 1'b0;
      case (op0) inside
        v3a_pkg::OP_CROSS: begin
          p0[i] = a0[(i+1)%L]; q0[i] = b0[(i+2)%L];
          p1[i] = a0[(i+2)%L]; q1[i] = b0[(i+1)%L]; sub1[i] = 1'b1;
        end
        v3a_pkg::OP_NORM, v3a_pkg::OP_LEN: begin
          q0[i] = a0[i];
        end
        v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: begin
          q0[i] = one_fx; p1[i] = b0[i]; q1[i] = one_fx;
          sub1[i] = (op0 == v3a_pkg::OP_SUB);
        end
        v3a_pkg::OP_SCALE, v3a_pkg::OP_DIV: begin
          q0[i] = s0;
        end
        default: ;
      endcase
    end
  end

  // side pipe alongside the two multiply stages
  logic v1, v2;
  v3a_pkg::op_t op1, op2;
  logic [W-1:0] a1 [L];
  logic [W-1:0] a2 [L];
  logic [W-1:0] s1, s2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else if (en) begin
      v1 <= v0; v2 <= v1;
    end
    if (en) begin
      op1 <= op0; op2 <= op1; s1 <= s0; s2 <= s1;
      a1 <= a0; a2 <= a1;
    end
  end

  // merge: total of the three lanes for dot, norm and length
  logic [SW+1:0] tot;
  assign tot = {{2{sum_l[0][SW-1]}}, sum_l[0]} + {{2{sum_l[1][SW-1]}}, sum_l[1]}
             + {{2{sum_l[2][SW-1]}}, sum_l[2]};

  logic sat_fx [L];
  logic [W-1:0] fx_l [L];
  logic sat_tot;
  logic [W-1:0] fx_tot;
  logic [SW+1:0] shl_tot;
  logic [SW-1:0] shl_l [L];

  function automatic logic [W:0] clip(input logic [SW+1:0] v);
    logic [SW+1:0] maxv, minv;
    maxv = (SW+2)'({1'b0, {(W-1){1'b1}}});
    minv = ~maxv;
    if ($signed(v) > $signed(maxv)) clip = {1'b1, 1'b0, {(W-1){1'b1}}};
    else if ($signed(v) < $signed(minv)) clip = {1'b1, 1'b1, {(W-1){1'b0}}};
    else clip = {1'b0, v[W-1:0]};
  endfunction

  always_comb begin
    logic [W:0] c;
    shl_tot = $signed(tot) >>> FRAC_BITS;
    c = clip(shl_tot);
    sat_tot = c[W];
    fx_tot = c[W-1:0];
    for (int i = 0; i < L; i++) begin
      shl_l[i] = (op2 == v3a_pkg::OP_ADD || op2 == v3a_pkg::OP_SUB) ? sum_l[i]
               : SW'($signed(sum_l[i]) >>> FRAC_BITS);
      c = clip({{2{shl_l[i][SW-1]}}, shl_l[i]});
      sat_fx[i] = c[W];
      fx_l[i] = c[W-1:0];
    end
  end

  // stage 3 register; then a square root pipe carrying the whole word
  typedef struct packed {
    logic [2:0] op;
    logic [L*W-1:0] a;
    logic [W-1:0] s;
    logic [L*W-1:0] r;
    logic [W-1:0] so;
    logic sat;
  } word_t;

  word_t w3, wsq [SQ_LAT];
  logic v3;
  logic [RAD_W-1:0] rad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      w3.op <= op2;
      w3.a <= {a2[2], a2[1], a2[0]};
      w3.s <= s2;
      w3.r <= {fx_l[2], fx_l[1], fx_l[0]};
      w3.so <= fx_tot;
      w3.sat <= (op2 == v3a_pkg::OP_DOT) ? sat_tot
              : (sat_fx[0] | sat_fx[1] | sat_fx[2]);
      rad3 <= tot[RAD_W-1:0];
    end
  end

  logic sqv;
  logic [RT_W-1:0] root;
  logic [TAG_W-1:0] sq_tag_unused;
  v3a_isqrt #(.IN_W(RAD_W), .OUT_W(RT_W), .TAG_W(TAG_W)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .radicand(rad3),
    .in_tag(w3.op), .out_valid(sqv), .root(root), .out_tag(sq_tag_unused)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      wsq[0] <= w3;
      for (int k = 1; k < SQ_LAT; k++) wsq[k] <= wsq[k-1];
    end
  end

  // after square root: pick the divisor and the error
  word_t wd;
  v3a_pkg::op_t opd;
  logic [W:0] den;
  logic dz;
  logic [W:0] len_c;
  always_comb begin
    logic [W:0] sm;
    wd = wsq[SQ_LAT-1];
    opd = v3a_pkg::op_t'(wd.op);
    sm = wd.s[W-1] ? -{wd.s[W-1], wd.s} : {1'b0, wd.s};
    den = (opd == v3a_pkg::OP_NORM) ? root : sm;
    dz = ((opd == v3a_pkg::OP_NORM) || (opd == v3a_pkg::OP_DIV)) && (den == '0);
    len_c = root;
    if (opd == v3a_pkg::OP_LEN) begin
      if (root[W] | root[W-1]) begin
        wd.so = {1'b0, {(W-1){1'b1}}};
        wd.sat = 1'b1;
      end else begin
        wd.so = len_c[W-1:0];
        wd.sat = 1'b0;
      end
    end
  end

  logic [L*W-1:0] av;
  logic dneg [L];
  assign av = wd.a;

  for (genvar i = 0; i < L; i++) begin : g_lane
    always_comb begin
      dneg[i] = (opd == v3a_pkg::OP_DIV) ? (av[i*W+W-1] ^ wd.s[W-1]) : av[i*W+W-1];
    end
    v3a_lane #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(W), .TAG_W(TAG_W)) u_lane (
      .clk(clk), .rst(rst), .en(en),
      .p0(p0[i]), .q0(q0[i]), .p1(p1[i]), .q1(q1[i]), .sub1(sub1[i]),
      .div_valid(sqv), .div_num(av[i*W +: W]),
      .div_den((den == '0) ? (W+1)'(1) : den), .div_neg(dneg[i]),
      .div_tag_in(3'(i)), .mul_sum(sum_l[i]), .div_out_valid(dval[i]),
      .div_q(q_l[i]), .div_tag_out(dtag[i])
    );
  end

  // word and flags ride beside the divider
  typedef struct packed {
    word_t w;
    logic dz;
  } dword_t;
  dword_t wdv [NW];
  always_ff @(posedge clk) begin
    if (en) begin
      wdv[0] <= '{w: wd, dz: dz};
      for (int k = 1; k < NW; k++) wdv[k] <= wdv[k-1];
    end
  end

  // final merge into the output register
  dword_t wf;
  v3a_pkg::op_t opf;
  logic [W:0] qc [L];
  always_comb begin
    wf = wdv[NW-1];
    opf = v3a_pkg::op_t'(wf.w.op);
    for (int i = 0; i < L; i++) qc[i] = clip({{(SW-QW+2){q_l[i][QW-1]}}, q_l[i]});
  end

  logic tag_ok;
  assign tag_ok = (dtag[0] == 3'd0) && (dtag[1] == 3'd1) && (dtag[2] == 3'd2)
                && dval[0] && dval[1] && dval[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tag_ok;
    end
    if (en) begin
      div_zero <= 1'b0;
      scalar_out <= '0;
      r_x <= '0; r_y <= '0; r_z <= '0;
      saturated <= wf.w.sat;
      case (opf) inside
        v3a_pkg::OP_DOT, v3a_pkg::OP_LEN: begin
          scalar_out <= wf.w.so;
        end
        v3a_pkg::OP_NORM, v3a_pkg::OP_DIV: begin
          if (wf.dz) begin
            div_zero <= 1'b1;
            saturated <= 1'b0;
          end else begin
            r_x <= qc[0][W-1:0]; r_y <= qc[1][W-1:0]; r_z <= qc[2][W-1:0];
            saturated <= qc[0][W] | qc[1][W] | qc[2][W];
          end
        end
        default: begin
          r_x <= wf.w.r[W-1:0]; r_y <= wf.w.r[2*W-1:W]; r_z <= wf.w.r[3*W-1:2*W];
        end
      endcase
    end
  end
endmodule

// ===== tb/sv/vec3_alu_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for vec3_alu: random and corner words, predicted results
module vec3_alu_tb;

  typedef struct {
    v3a_pkg::op_t op;
    logic signed [31:0] ax, ay, az, bx, by, bz, s;
  } vec_word_t;

  typedef struct {
    logic [31:0] rx, ry, rz, so;
    logic dz, sat;
  } vec_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0, scalar_in = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [31:0] r_x, r_y, r_z, scalar_out;
  logic div_zero, saturated;

  vec_word_t pending_words[$];
  vec_result_t expected_results[$];
  vec_word_t cur_word;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int total_words = 0;
  int hold_cycles = 0;
  bit hold_done = 0;

  vec3_alu dut (.*);

  always #4 clk = ~clk;

  function automatic logic [31:0] clip(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sh7fffffff) begin
      sat = 1;
      return 32'h7fffffff;
    end
    if (v < -128'sh80000000) begin
      sat = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] magnitude(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] fx_divide(input logic signed [127:0] num,
                                            input logic signed [127:0] den, inout bit sat);
    logic signed [127:0] q;
    q = (magnitude(num) << 16) / magnitude(den);
    if ((num < 0) != (den < 0)) q = -q;
    return clip(q, sat);
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] r, c;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic vec_result_t vec_predict(input vec_word_t w);
    vec_result_t res;
    logic signed [127:0] a[3], b[3], s, acc, len;
    bit sat;
    sat = 0;
    a[0] = w.ax; a[1] = w.ay; a[2] = w.az;
    b[0] = w.bx; b[1] = w.by; b[2] = w.bz;
    s = w.s;
    res = '{default: '0};
    case (w.op)
      v3a_pkg::OP_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        res.so = clip(acc >>> 16, sat);
      end
      v3a_pkg::OP_CROSS: begin
        res.rx = clip((a[1] * b[2] - a[2] * b[1]) >>> 16, sat);
        res.ry = clip((a[2] * b[0] - a[0] * b[2]) >>> 16, sat);
        res.rz = clip((a[0] * b[1] - a[1] * b[0]) >>> 16, sat);
      end
      v3a_pkg::OP_NORM, v3a_pkg::OP_LEN: begin
        len = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (w.op == v3a_pkg::OP_LEN) res.so = clip(len, sat);
        else if (len == 0) res.dz = 1;
        else begin
          res.rx = fx_divide(a[0], len, sat);
          res.ry = fx_divide(a[1], len, sat);
          res.rz = fx_divide(a[2], len, sat);
        end
      end
      v3a_pkg::OP_ADD: begin
        res.rx = clip(a[0] + b[0], sat);
        res.ry = clip(a[1] + b[1], sat);
        res.rz = clip(a[2] + b[2], sat);
      end
      v3a_pkg::OP_SUB: begin
        res.rx = clip(a[0] - b[0], sat);
        res.ry = clip(a[1] - b[1], sat);
        res.rz = clip(a[2] - b[2], sat);
      end
      v3a_pkg::OP_SCALE: begin
        res.rx = clip((a[0] * s) >>> 16, sat);
        res.ry = clip((a[1] * s) >>> 16, sat);
        res.rz = clip((a[2] * s) >>> 16, sat);
      end
      default: begin
        if (s == 0) res.dz = 1;
        else begin
          res.rx = fx_divide(a[0], s, sat);
          res.ry = fx_divide(a[1], s, sat);
          res.rz = fx_divide(a[2], s, sat);
        end
      end
    endcase
    res.sat = sat;
    return res;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 5))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'h0;
        3: return 32'hffffffff;
        4: return 32'h00010000;
        default: return 32'hffff0000;
      endcase
      1, 2, 3, 4: return $urandom_range(0, 32'h200000) - 32'h100000;
      5, 6: return $urandom_range(0, 32'h10000000) - 32'h08000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_word(input v3a_pkg::op_t op, input logic [31:0] ax, ay, az, bx, by, bz,
                          s);
    vec_word_t w;
    w.op = op;
    w.ax = ax; w.ay = ay; w.az = az;
    w.bx = bx; w.by = by; w.bz = bz;
    w.s = s;
    pending_words.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin
    automatic bit quiet = words_sent >= 400 && words_sent < 550;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(vec_predict(cur_word));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
          cur_word = pending_words.pop_front();
          in_valid <= 1;
          operation <= cur_word.op;
          a_x <= cur_word.ax; a_y <= cur_word.ay; a_z <= cur_word.az;
          b_x <= cur_word.bx; b_y <= cur_word.by; b_z <= cur_word.bz;
          scalar_in <= cur_word.s;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vec_result_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (r_x !== e.rx) begin
            $error("r_x expected %h got %h", e.rx, r_x); errors++;
          end
          if (r_y !== e.ry) begin
            $error("r_y expected %h got %h", e.ry, r_y); errors++;
          end
          if (r_z !== e.rz) begin
            $error("r_z expected %h got %h", e.rz, r_z); errors++;
          end
          if (scalar_out !== e.so) begin
            $error("scalar_out expected %h got %h", e.so, scalar_out); errors++;
          end
          if (div_zero !== e.dz) begin
            $error("div_zero expected %b got %b", e.dz, div_zero); errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %b got %b", e.sat, saturated); errors++;
          end
        end
      end
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 0;
      end else begin
        out_ready <= (results_seen >= 400 && results_seen < 550) ||
                     $urandom_range(0, 99) >= 15;
      end
    end
  end

  initial begin
    automatic logic [31:0] mx = 32'h7fffffff, mn = 32'h80000000, one = 32'h00010000;
    for (int k = 0; k < 8; k++) begin
      add_word(v3a_pkg::op_t'(k), mx, mx, mx, mx, mx, mx, mx);
      add_word(v3a_pkg::op_t'(k), mn, mn, mn, mn, mn, mn, mn);
    end
    add_word(v3a_pkg::OP_NORM, 0, 0, 0, one, one, one, one);
    add_word(v3a_pkg::OP_LEN, 0, 0, 0, 0, 0, 0, 0);
    add_word(v3a_pkg::OP_DIV, one, mn, mx, 0, 0, 0, 0);
    add_word(v3a_pkg::OP_DIV, mx, mn, one, 0, 0, 0, 1);
    add_word(v3a_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
    add_word(v3a_pkg::OP_CROSS, mx, mn, mx, mn, mx, mn, 0);
    add_word(v3a_pkg::OP_ADD, mx, mn, 0, 1, 32'hffffffff, 0, 0);
    add_word(v3a_pkg::OP_SCALE, one, 32'hffff0000, mn, 0, 0, 0, 32'hffff0000);
    for (int k = 0; k < 830; k++) begin
      vec_word_t w;
      w.op = v3a_pkg::op_t'($urandom_range(0, 7));
      w.ax = pick_value(); w.ay = pick_value(); w.az = pick_value();
      w.bx = pick_value(); w.by = pick_value(); w.bz = pick_value();
      w.s = $urandom_range(0, 15) == 0 ? 32'h0 : pick_value();
      if (w.op == v3a_pkg::OP_NORM && $urandom_range(0, 15) == 0) begin
        w.ax = 0; w.ay = 0; w.az = 0;
      end
      pending_words.push_back(w);
    end
    total_words = pending_words.size();
    repeat (10) @(posedge clk);
    rst <= 0;
    wait (results_seen >= total_words);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0 && words_sent == total_words &&
        results_seen == total_words)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
